>>> rtl/msd_pkg.sv
`timescale 1ns / 1ps

package msd_pkg;

    // Sizing
    localparam int MOTORS      = 16;
    localparam int POSITIONS   = 2048;
    localparam int SAMPLE_BITS = 10;

    localparam int MOT_AW     = (MOTORS > 1) ? $clog2(MOTORS) : 1;
    localparam int PROF_DEPTH = MOTORS * POSITIONS;
    localparam int PROF_AW    = $clog2(PROF_DEPTH);

    // Field widths fixed by the stream format
    localparam int REQ_W   = 2;
    localparam int MOTOR_W = 4;
    localparam int SMP_W   = 10;
    localparam int POS_W   = 11;
    localparam int CNT_W   = 4;
    localparam int SUM_W   = 14;

    localparam logic [SUM_W-1:0] SUM_MAX  = '1;
    localparam logic [SMP_W-1:0] SMP_MASK = SMP_W'((64'd1 << SAMPLE_BITS) - 64'd1);

    // Request kinds
    localparam logic [REQ_W-1:0] REQ_SAMPLE = 2'd0;
    localparam logic [REQ_W-1:0] REQ_RECORD = 2'd1;
    localparam logic [REQ_W-1:0] REQ_ARM    = 2'd2;

    // Configuration register indexes
    localparam int CFG_AW    = 3;
    localparam int CFG_DW    = 14;
    localparam logic [CFG_AW-1:0] CFG_DETECT_EN  = 3'd0;
    localparam logic [CFG_AW-1:0] CFG_ACTIVE_MOT = 3'd1;
    localparam logic [CFG_AW-1:0] CFG_WINDOW_LEN = 3'd2;
    localparam logic [CFG_AW-1:0] CFG_STILL_DLT  = 3'd3;
    localparam logic [CFG_AW-1:0] CFG_DEV_LIMIT  = 3'd4;
    localparam logic [CFG_AW-1:0] CFG_END_MARGIN = 3'd5;

    // Output queue
    localparam int OUT_DEPTH = 4;
    localparam int OUT_AW    = $clog2(OUT_DEPTH);

    // Per-motor state word
    typedef struct packed {
        logic             active;
        logic [CNT_W-1:0] count;
        logic [SUM_W-1:0] sum;
        logic [SUM_W-1:0] prev;
    } mstate_t;

    typedef struct packed {
        logic               stall;
        logic [MOTOR_W-1:0] motor;
        logic               closed;
    } result_t;

endpackage

>>> rtl/motor_stall_detector.sv
`timescale 1ns / 1ps

// Per-motor stall detector.
// s_ channel carries one request per beat: tuser is the request kind
// (sample check, profile record, arm motor); tdata holds motor, sample,
// position and total travel. Only sample checks return a beat on m_,
// carrying the stall flag, the motor index and the window-closed flag.
// Configuration is a plain write port; the user must use it only while the
// block is idle, and the block itself does not enforce this. A result passes
// through the update stage registers and the output queue before m_tvalid rises.
// Throughput: one request per cycle while s_tready is high. The per-motor
// state lives in a one-read one-write synchronous memory (read at accept,
// written back in the next cycle, with forwarding for back-to-back beats on
// one motor); this read-modify-write loop sets the rate.
// Results wait in a four-beat output queue; when the receiver stalls and
// the queue fills, s_tready drops until room is made.
// Reset clears the per-motor state at once through per-entry valid bits
// and restores the register defaults; there is no clearing pass. s_tready
// is low during reset. The profile memory is not cleared and must be
// recorded before it is used.
module motor_stall_detector (
    input  logic                          aclk,
    input  logic                          aresetn,
    // configuration writes
    input  logic                          cfg_we,
    input  logic [msd_pkg::CFG_AW-1:0]    cfg_index,
    input  logic [msd_pkg::CFG_DW-1:0]    cfg_wdata,
    // request stream
    input  logic                          s_tvalid,
    output logic                          s_tready,
    input  logic [39:0]                   s_tdata,  // motor, sample, position, total_steps, pad
    input  logic [1:0]                    s_tuser,  // req_type
    // result stream
    output logic                          m_tvalid,
    input  logic                          m_tready,
    output logic [7:0]                    m_tdata   // stall_res, motor_out, window_closed, pad
);
    import msd_pkg::*;

    // Configuration registers
    logic             detect_en_reg;
    logic [4:0]       active_mot_reg;
    logic [CNT_W-1:0] window_len_reg;
    logic [SUM_W-1:0] still_dlt_reg;
    logic [SMP_W-1:0] dev_limit_reg;
    logic [POS_W-1:0] end_margin_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            detect_en_reg  <= 1'b0;
            active_mot_reg <= 5'd0;
            window_len_reg <= 4'd12;
            still_dlt_reg  <= 14'd8;
            dev_limit_reg  <= 10'd300;
            end_margin_reg <= 11'd200;
        end else if (cfg_we) begin
            unique case (cfg_index)
                CFG_DETECT_EN:  detect_en_reg  <= cfg_wdata[0];
                CFG_ACTIVE_MOT: active_mot_reg <= cfg_wdata[4:0];
                CFG_WINDOW_LEN: window_len_reg <= cfg_wdata[CNT_W-1:0];
                CFG_STILL_DLT:  still_dlt_reg  <= cfg_wdata[SUM_W-1:0];
                CFG_DEV_LIMIT:  dev_limit_reg  <= cfg_wdata[SMP_W-1:0];
                CFG_END_MARGIN: end_margin_reg <= cfg_wdata[POS_W-1:0];
                default: ;
            endcase
        end
    end

    // Input unpacking
    logic [REQ_W-1:0]   in_req;
    logic [MOTOR_W-1:0] in_motor;
    logic [SMP_W-1:0]   in_smp;
    logic [POS_W-1:0]   in_pos;
    logic [POS_W-1:0]   in_total;
    logic               s_accept;
    logic               in_mot_ok;
    logic               in_pos_ok;
    logic [MOT_AW-1:0]  in_maddr;
    logic [PROF_AW-1:0] in_paddr;

    assign in_req    = s_tuser;
    assign in_motor  = s_tdata[3:0];
    assign in_smp    = s_tdata[13:4] & SMP_MASK;
    assign in_pos    = s_tdata[24:14];
    assign in_total  = s_tdata[35:25];
    assign s_accept  = s_tvalid && s_tready;
    assign in_mot_ok = int'(in_motor) < MOTORS;
    assign in_pos_ok = int'(in_pos) < POSITIONS;
    assign in_maddr  = MOT_AW'(in_motor);
    assign in_paddr  = PROF_AW'(int'(in_motor) * POSITIONS + int'(in_pos));

    // Profile memory: written at accept, read at accept for the next stage
    logic [SMP_W-1:0] prof_mem [PROF_DEPTH];
    logic [SMP_W-1:0] prof_q_reg;
    logic             prof_we;

    assign prof_we = s_accept && (in_req == REQ_RECORD) && in_mot_ok && in_pos_ok;

    always_ff @(posedge aclk) begin
        if (prof_we) begin
            prof_mem[in_paddr] <= in_smp;
        end
        if (s_accept) begin
            prof_q_reg <= prof_mem[in_paddr];
        end
    end

    // Per-motor state memory with valid bits standing in for the reset value
    mstate_t           st_mem [MOTORS];
    mstate_t           st_q_reg;
    logic [MOTORS-1:0] st_valid_reg;
    logic              st_vq_reg;
    logic              st_we;
    logic [MOT_AW-1:0] st_waddr;
    mstate_t           st_wdata;

    always_ff @(posedge aclk) begin
        if (st_we) begin
            st_mem[st_waddr] <= st_wdata;
        end
        if (s_accept) begin
            st_q_reg <= st_mem[in_maddr];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            st_valid_reg <= '0;
            st_vq_reg    <= 1'b0;
        end else begin
            if (st_we) begin
                st_valid_reg[st_waddr] <= 1'b1;
            end
            if (s_accept) begin
                st_vq_reg <= st_valid_reg[in_maddr];
            end
        end
    end

    // Update stage registers
    logic               s1_valid_reg;
    logic [REQ_W-1:0]   s1_req_reg;
    logic [MOTOR_W-1:0] s1_motor_reg;
    logic [MOT_AW-1:0]  s1_maddr_reg;
    logic               s1_mot_ok_reg;
    logic               s1_pos_ok_reg;
    logic [SMP_W-1:0]   s1_smp_reg;
    logic [POS_W-1:0]   s1_pos_reg;
    logic [POS_W-1:0]   s1_total_reg;
    logic               fwd_hit_reg;
    mstate_t            fwd_data_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            s1_valid_reg <= 1'b0;
            fwd_hit_reg  <= 1'b0;
        end else begin
            s1_valid_reg <= s_accept;
            // the write landing this edge is not seen by the read beside it
            fwd_hit_reg  <= s_accept && st_we && (st_waddr == in_maddr);
        end
        if (s_accept) begin
            s1_req_reg    <= in_req;
            s1_motor_reg  <= in_motor;
            s1_maddr_reg  <= in_maddr;
            s1_mot_ok_reg <= in_mot_ok;
            s1_pos_ok_reg <= in_pos_ok;
            s1_smp_reg    <= in_smp;
            s1_pos_reg    <= in_pos;
            s1_total_reg  <= in_total;
            fwd_data_reg  <= st_wdata;
        end
    end

    // Read-modify-write of the motor state
    mstate_t          cur;
    logic [SMP_W-1:0] ref_smp;
    logic             check;
    logic [SUM_W:0]   sum_add;
    logic [SUM_W-1:0] d_sum;
    logic [SMP_W-1:0] d_smp;
    logic [POS_W-1:0] d_pos;
    logic             stall;
    logic             closed;
    logic             push;

    assign ref_smp = s1_pos_ok_reg ? prof_q_reg : '0;
    assign sum_add = {1'b0, cur.sum} + (SUM_W+1)'(s1_smp_reg);
    assign d_sum   = (cur.prev > cur.sum) ? cur.prev - cur.sum : cur.sum - cur.prev;
    assign d_smp   = (s1_smp_reg > ref_smp) ? s1_smp_reg - ref_smp : ref_smp - s1_smp_reg;
    assign d_pos   = (s1_pos_reg > s1_total_reg) ? s1_pos_reg - s1_total_reg
                                                 : s1_total_reg - s1_pos_reg;
    assign check   = detect_en_reg && s1_mot_ok_reg
                     && ({1'b0, s1_motor_reg} < active_mot_reg) && cur.active;
    assign push    = s1_valid_reg && (s1_req_reg == REQ_SAMPLE);
    assign st_waddr = s1_maddr_reg;

    always_comb begin
        if (fwd_hit_reg) begin
            cur = fwd_data_reg;
        end else if (st_vq_reg) begin
            cur = st_q_reg;
        end else begin
            cur = '0;
        end
        st_wdata = cur;
        st_we    = 1'b0;
        stall    = 1'b0;
        closed   = 1'b0;
        if (s1_valid_reg && (s1_req_reg == REQ_ARM) && s1_mot_ok_reg) begin
            st_we           = 1'b1;
            st_wdata.active = 1'b1;
        end else if (push && check) begin
            st_we = 1'b1;
            priority if (cur.count < window_len_reg) begin
                st_wdata.count = cur.count + 1'b1;
                st_wdata.sum   = (sum_add > (SUM_W+1)'(SUM_MAX)) ? SUM_MAX
                                                                 : sum_add[SUM_W-1:0];
            end else if (cur.prev == '0) begin
                st_wdata.prev = cur.sum;
            end else begin
                stall = (d_sum < still_dlt_reg) && (d_smp > dev_limit_reg)
                        && (d_pos > end_margin_reg) && (s1_pos_reg > end_margin_reg);
                if (stall) begin
                    st_wdata.active = 1'b0;
                end
                st_wdata.prev  = cur.sum;
                st_wdata.count = '0;
                st_wdata.sum   = '0;
                closed         = 1'b1;
            end
        end
    end

    // Output queue
    result_t         oq_mem [OUT_DEPTH];
    logic [OUT_AW-1:0] oq_wr_reg;
    logic [OUT_AW-1:0] oq_rd_reg;
    logic [OUT_AW:0]   oq_cnt_reg;
    logic [OUT_AW:0]   oq_cnt_next;
    logic              pop;
    result_t           oq_head;

    assign pop      = m_tvalid && m_tready;
    assign s_tready = aresetn
                      && ((oq_cnt_reg + (OUT_AW+1)'(s1_valid_reg)) < (OUT_AW+1)'(OUT_DEPTH));
    assign oq_cnt_next = oq_cnt_reg + (OUT_AW+1)'(push) - (OUT_AW+1)'(pop);

    always_ff @(posedge aclk) begin
        if (push) begin
            oq_mem[oq_wr_reg] <= '{stall: stall, motor: s1_motor_reg, closed: closed};
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            oq_wr_reg  <= '0;
            oq_rd_reg  <= '0;
            oq_cnt_reg <= '0;
        end else begin
            if (push) begin
                oq_wr_reg <= oq_wr_reg + 1'b1;
            end
            if (pop) begin
                oq_rd_reg <= oq_rd_reg + 1'b1;
            end
            oq_cnt_reg <= oq_cnt_next;
        end
    end

    assign oq_head  = oq_mem[oq_rd_reg];
    assign m_tvalid = (oq_cnt_reg != '0);
    assign m_tdata  = {2'b00, oq_head.closed, oq_head.motor, oq_head.stall};

    // Checks
    a_oq_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        oq_cnt_reg <= (OUT_AW+1)'(OUT_DEPTH))
        else $error("output queue over-filled");

    a_stall_closes: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tdata[0] |-> m_tdata[5])
        else $error("stall reported without a closed window");

    a_fwd_needs_stage: assert property (@(posedge aclk) disable iff (!aresetn)
        fwd_hit_reg |-> s1_valid_reg)
        else $error("forwarding without an item in the update stage");

    a_arm_writes: assert property (@(posedge aclk) disable iff (!aresetn)
        s_accept && (in_req == REQ_ARM) && in_mot_ok |=> st_we && st_wdata.active)
        else $error("arm request did not set the motor active");

endmodule
